FILE: hdl/cd128_pkg.sv
// Shared types, constants and helpers for the Code 128 set B encoder.
// No dependencies; imported by every module under hdl/.
package cd128_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam int unsigned FifoAw    = $clog2(FifoDepth);

    localparam logic [6:0]  START_B_VALUE = 7'd104;
    localparam logic [6:0]  STOP_VALUE    = 7'd106;
    localparam logic [6:0]  CHECK_MOD     = 7'd103;
    localparam logic [6:0]  CHAR_OFFSET   = 7'd32;
    localparam logic [6:0]  CHECK_INIT    = 7'd1;   // 104 mod 103
    localparam logic [6:0]  POS_INIT      = 7'd1;
    localparam logic [1:0]  STOP_LAST_BAR = 2'd2;
    // floor(x / 103) == (x * 10181) >> 20 for all x < 15650
    localparam logic [13:0] RECIP_103     = 14'd10181;
    localparam int unsigned RECIP_SHIFT   = 20;

    // One queued character: flags plus value and its weighted term
    typedef struct packed {
        logic        first;
        logic        last;
        logic [6:0]  value;
        logic [13:0] prod;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_CHAR,
        PH_CHECK,
        PH_STOP
    } t_phase;

    // Six widths per symbol, one nibble each, first bar in the top nibble
    localparam logic [23:0] PATTERN_ROM [0:106] = '{
        24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
        24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
        24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
        24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
        24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
        24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
        24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
        24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
        24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
        24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
        24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
        24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
        24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
        24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
        24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
        24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
        24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
        24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
        24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
        24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
        24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
        24'h211232, 24'h233111
    };

    function automatic logic [23:0] pattern_of(input logic [6:0] v);
        logic [23:0] p;
        p = 24'h0;
        if (v <= STOP_VALUE) begin
            p = PATTERN_ROM[v];
        end
        return p;
    endfunction

    // x mod 103 for x below 13184, by reciprocal multiply
    function automatic logic [6:0] mod103(input logic [13:0] x);
        logic [27:0] t;
        logic [6:0]  q;
        logic [13:0] qm;
        logic [13:0] r;
        t  = 28'(x) * 28'(RECIP_103);
        q  = t[RECIP_SHIFT +: 7];
        qm = 14'(q) * 14'(CHECK_MOD);
        r  = x - qm;
        return r[6:0];
    endfunction

endpackage

FILE: hdl/cd128_front.sv
// Front end: accepts characters, tracks message start and position weight,
// and builds one queue command per character. Depends on cd128_pkg.
module cd128_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [6:0]           i_char_code,
    input  logic                 i_last_char,
    input  logic                 i_full,
    output logic                 o_stall,
    output logic                 o_push,
    output cd128_pkg::t_cmd      o_cmd
);
    import cd128_pkg::*;

    logic       r_in_msg;
    logic [6:0] r_weight;
    logic [6:0] weight;
    logic [6:0] value;
    logic [6:0] weight_inc;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    // controls below 32 count as space
    assign value  = (i_char_code >= CHAR_OFFSET) ? (i_char_code - CHAR_OFFSET) : 7'd0;
    assign weight = r_in_msg ? r_weight : POS_INIT;
    assign weight_inc = (weight == (CHECK_MOD - 7'd1)) ? 7'd0 : (weight + 7'd1);

    always_comb begin
        o_cmd.first = !r_in_msg;
        o_cmd.last  = i_last_char;
        o_cmd.value = value;
        o_cmd.prod  = 14'(value) * 14'(weight);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_weight <= POS_INIT;
        end else if (accept) begin
            r_in_msg <= !i_last_char;
            r_weight <= i_last_char ? POS_INIT : weight_inc;
        end
    end

endmodule

FILE: hdl/cd128_fifo.sv
// Small command queue between front and back ends.
// Depends on cd128_pkg for the command type and depth.
module cd128_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cd128_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_nonempty,
    output cd128_pkg::t_cmd      o_head
);
    import cd128_pkg::*;

    t_cmd                r_mem [FifoDepth];
    logic [FifoAw-1:0]   r_wr_ptr;
    logic [FifoAw-1:0]   r_rd_ptr;
    logic [FifoAw:0]     r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full     = (r_count == (FifoAw+1)'(FifoDepth));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FifoAw'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FifoAw'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (FifoAw+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (FifoAw+1)'(1);
            end
        end
    end

endmodule

FILE: hdl/cd128_back.sv
// Back end: expands each command into start / char / check / stop symbols,
// keeps the running check and drives the output register. Depends on cd128_pkg.
module cd128_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  cd128_pkg::t_cmd      i_head,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [6:0]           o_symbol_value,
    output logic [2:0]           o_width_a,
    output logic [2:0]           o_width_b,
    output logic [2:0]           o_width_c,
    output logic [2:0]           o_width_d,
    output logic [2:0]           o_width_e,
    output logic [2:0]           o_width_f,
    output logic [1:0]           o_width_g,
    output logic                 o_frame_end
);
    import cd128_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [6:0]  r_cks;
    logic [6:0]  n_cks;
    logic        r_valid;
    logic [6:0]  r_sym;
    logic [23:0] r_pat;

    logic        fire;
    logic        start_step;
    logic        char_step;
    logic [6:0]  sym;
    logic [7:0]  cks_sum;

    assign fire = i_head_valid && (!r_valid || !i_stall);

    // next state
    always_comb begin
        n_phase = r_phase;
        if (fire) begin
            unique case (r_phase)
                PH_HEAD: begin
                    if (i_head.first) begin
                        n_phase = PH_CHAR;
                    end else begin
                        n_phase = i_head.last ? PH_CHECK : PH_HEAD;
                    end
                end
                PH_CHAR:  n_phase = i_head.last ? PH_CHECK : PH_HEAD;
                PH_CHECK: n_phase = PH_STOP;
                PH_STOP:  n_phase = PH_HEAD;
                default:  n_phase = PH_HEAD;
            endcase
        end
    end

    // per-phase symbol select and side effects
    always_comb begin
        sym        = i_head.value;
        start_step = 1'b0;
        char_step  = 1'b0;
        o_pop      = 1'b0;
        unique case (r_phase)
            PH_HEAD: begin
                if (i_head.first) begin
                    sym        = START_B_VALUE;
                    start_step = fire;
                end else begin
                    char_step = fire;
                    o_pop     = fire && !i_head.last;
                end
            end
            PH_CHAR: begin
                char_step = fire;
                o_pop     = fire && !i_head.last;
            end
            PH_CHECK: sym = r_cks;
            PH_STOP: begin
                sym   = STOP_VALUE;
                o_pop = fire;
            end
            default: sym = i_head.value;
        endcase
    end

    // running check, kept below 103
    always_comb begin
        cks_sum = 8'(r_cks) + 8'(mod103(i_head.prod));
        n_cks   = r_cks;
        if (start_step) begin
            n_cks = CHECK_INIT;
        end else if (char_step) begin
            n_cks = (cks_sum >= 8'(CHECK_MOD)) ? 7'(cks_sum - 8'(CHECK_MOD)) : cks_sum[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_cks   <= CHECK_INIT;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cks   <= n_cks;
            if (fire) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_sym <= sym;
            r_pat <= pattern_of(sym);
        end
    end

    assign o_valid        = r_valid;
    assign o_symbol_value = r_sym;
    assign o_width_a      = r_pat[22:20];
    assign o_width_b      = r_pat[18:16];
    assign o_width_c      = r_pat[14:12];
    assign o_width_d      = r_pat[10:8];
    assign o_width_e      = r_pat[6:4];
    assign o_width_f      = r_pat[2:0];
    assign o_frame_end    = (r_sym == STOP_VALUE);
    assign o_width_g      = (r_sym == STOP_VALUE) ? STOP_LAST_BAR : 2'd0;

endmodule

FILE: hdl/code128b_symbol_encoder.sv
// Top level of the Code 128 set B symbol encoder: front end, command queue
// and back end. Depends on cd128_pkg, cd128_front, cd128_fifo, cd128_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_stall  | i_char_code, i_last_char
//  output   | o_valid / i_stall  | o_symbol_value, o_width_a..g, o_frame_end
//
// Flow: the front takes one character per clock while the 4-word queue has
// room. The back sends one symbol word per clock while the queue holds a
// command and i_stall is low. Each character gives one symbol, plus Start B
// before a first one and check and stop after a last: n characters, n+3 symbols.
// Reset: synchronous, active low; clears the queue, message state, check.
// Stalls: the output register holds while i_stall is high; the queue then
// fills and o_stall rises when it is full.
module code128b_symbol_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [6:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_symbol_value,
    output logic [2:0] o_width_a,
    output logic [2:0] o_width_b,
    output logic [2:0] o_width_c,
    output logic [2:0] o_width_d,
    output logic [2:0] o_width_e,
    output logic [2:0] o_width_f,
    output logic [1:0] o_width_g,
    output logic       o_frame_end
);
    import cd128_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic nonempty;

    // Front: character in, weighted term computed, one command queued.
    cd128_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Queue decouples the one-in front from the up-to-four-out back.
    cd128_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_cmd      (push_cmd),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head_cmd)
    );

    // Back: symbol sequencing, check accumulation, pattern lookup.
    cd128_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (nonempty),
        .i_head         (head_cmd),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_symbol_value (o_symbol_value),
        .o_width_a      (o_width_a),
        .o_width_b      (o_width_b),
        .o_width_c      (o_width_c),
        .o_width_d      (o_width_d),
        .o_width_e      (o_width_e),
        .o_width_f      (o_width_f),
        .o_width_g      (o_width_g),
        .o_frame_end    (o_frame_end)
    );

endmodule
